// ===== hw/rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types, constants and helpers of the matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int ELEM_W        = 16;   // matrix entry and quaternion width
    localparam int NUM_W         = 17;   // sum or difference of two entries
    localparam int QB            = 17;   // quotient bits kept before saturation
    localparam int IN_W          = 9 * ELEM_W;
    localparam int OUT_W         = 4 * ELEM_W;

    // branch codes: diagonal index, or trace branch
    localparam logic [1:0] SEL_I0    = 2'd0;
    localparam logic [1:0] SEL_I1    = 2'd1;
    localparam logic [1:0] SEL_I2    = 2'd2;
    localparam logic [1:0] SEL_TRACE = 2'd3;

    typedef struct packed {
        logic [1:0]              sel;
        logic                    degen;
        logic signed [NUM_W-1:0] d0;
        logic signed [NUM_W-1:0] d1;
        logic signed [NUM_W-1:0] d2;
    } t_sq_carry;

    typedef struct packed {
        logic [1:0]        sel;
        logic              degen;
        logic [ELEM_W-1:0] half;
        logic [2:0]        neg;
    } t_dv_carry;

    // signed saturation of a sign and magnitude quotient
    function automatic logic [ELEM_W-1:0] sat16(input logic neg, input logic ovf,
                                                input logic [QB-1:0] q);
        logic [ELEM_W-1:0] r;
        if (neg) begin
            if (ovf || q > QB'(32768)) r = 16'h8000;
            else                        r = -q[ELEM_W-1:0];
        end else begin
            if (ovf || q > QB'(32767)) r = 16'h7fff;
            else                        r = q[ELEM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/rotation_matrix_to_quaternion_top.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// rotation matrix to unit quaternion, pipelined square root and dividers
// ----------------------------------------------------------------------------
// usage
//   slave stream: one transfer carries a 3x3 matrix, nine signed Q2.14
//   entries, row-major, m00 in the lowest bits
//   master stream: one transfer per matrix with qw,qx,qy,qz in tdata and the
//   degenerate flag in tuser (set when the square root came out zero; the
//   quaternion is then all zero)
//   throughput: one matrix per cycle while the skid register is empty, every
//   stage is a register stage; RTW is the root width (17 at 14 fraction
//   bits); the
//   square root takes one result bit per stage, each divider one quotient
//   bit per stage
//   reset: synchronous active low, clears all valid bits; the pipeline is
//   empty and o_s_axis_tready is high
//   stall: when the receiver holds tready low the last result waits in the
//   output register and one more lands in a skid register; the pipeline
//   only freezes once the skid is full, so no transfer is lost or repeated
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // qw, qx, qy, qz (16 bits each)
    output logic [OUT_W-1:0] o_m_axis_tdata,
    // degenerate
    output logic             o_m_axis_tuser
);

    // radicand width (signed), shifted radicand width, root width
    localparam int RSW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int SW  = RSW - 1 + FRAC_BITS;
    localparam int RTW = (SW + 1) / 2;
    localparam int VW  = 2 * RTW;
    // divider working width
    localparam int WA  = NUM_W + FRAC_BITS + 1;
    localparam int WB  = RTW + QB + 2;
    localparam int WW  = ((WA > WB) ? WA : WB) + 1;
    localparam int HX  = RTW + ELEM_W + 1;

    // pipeline advances while the skid register is free
    logic r_skid_v;
    logic en;
    assign en = ~r_skid_v;
    assign o_s_axis_tready = en;

    // ---------------- stage 1: latch entries, trace and diagonal pick
    logic                     r_s1_v;
    logic signed [ELEM_W-1:0] r_s1_m [9];
    logic signed [RSW-1:0]    r_s1_t1;
    logic [1:0]               r_s1_i;

    logic signed [ELEM_W-1:0] in_m [9];
    logic signed [RSW-1:0]    n_s1_t1;
    logic [1:0]               n_s1_i;

    always_comb begin
        for (int e = 0; e < 9; e++) begin
            in_m[e] = i_s_axis_tdata[e*ELEM_W +: ELEM_W];
        end
        n_s1_t1 = RSW'(in_m[0]) + RSW'(in_m[4]) + RSW'(in_m[8])
                + (RSW'(1) << FRAC_BITS);
        n_s1_i  = SEL_I0;
        if (in_m[4] > in_m[0]) n_s1_i = SEL_I1;
        if (n_s1_i == SEL_I1) begin
            if (in_m[8] > in_m[4]) n_s1_i = SEL_I2;
        end else begin
            if (in_m[8] > in_m[0]) n_s1_i = SEL_I2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_s_axis_tvalid;
        end
        if (en) begin
            r_s1_m  <= in_m;
            r_s1_t1 <= n_s1_t1;
            r_s1_i  <= n_s1_i;
        end
    end

    // ---------------- stage 2: radicand, numerators, branch
    logic signed [RSW-1:0] rad_s;
    logic [RSW-2:0]        rad_u;
    t_sq_carry             n_c2;

    always_comb begin
        n_c2.sel = (r_s1_t1[RSW-1]) ? r_s1_i : SEL_TRACE;
        unique case (n_c2.sel)
            SEL_I0: rad_s = RSW'(r_s1_m[0]) - RSW'(r_s1_m[4]) - RSW'(r_s1_m[8])
                          + (RSW'(1) << FRAC_BITS);
            SEL_I1: rad_s = RSW'(r_s1_m[4]) - RSW'(r_s1_m[8]) - RSW'(r_s1_m[0])
                          + (RSW'(1) << FRAC_BITS);
            SEL_I2: rad_s = RSW'(r_s1_m[8]) - RSW'(r_s1_m[0]) - RSW'(r_s1_m[4])
                          + (RSW'(1) << FRAC_BITS);
            default: rad_s = r_s1_t1;
        endcase
        // non-positive radicand gives a zero root
        n_c2.degen = rad_s[RSW-1] || (rad_s == '0);
        rad_u      = n_c2.degen ? '0 : rad_s[RSW-2:0];

        unique case (n_c2.sel)
            SEL_I0: begin
                n_c2.d0 = NUM_W'(r_s1_m[7]) - NUM_W'(r_s1_m[5]);
                n_c2.d1 = NUM_W'(r_s1_m[1]) + NUM_W'(r_s1_m[3]);
                n_c2.d2 = NUM_W'(r_s1_m[2]) + NUM_W'(r_s1_m[6]);
            end
            SEL_I1: begin
                n_c2.d0 = NUM_W'(r_s1_m[2]) - NUM_W'(r_s1_m[6]);
                n_c2.d1 = NUM_W'(r_s1_m[5]) + NUM_W'(r_s1_m[7]);
                n_c2.d2 = NUM_W'(r_s1_m[3]) + NUM_W'(r_s1_m[1]);
            end
            SEL_I2: begin
                n_c2.d0 = NUM_W'(r_s1_m[3]) - NUM_W'(r_s1_m[1]);
                n_c2.d1 = NUM_W'(r_s1_m[6]) + NUM_W'(r_s1_m[2]);
                n_c2.d2 = NUM_W'(r_s1_m[7]) + NUM_W'(r_s1_m[5]);
            end
            default: begin
                n_c2.d0 = NUM_W'(r_s1_m[7]) - NUM_W'(r_s1_m[5]);
                n_c2.d1 = NUM_W'(r_s1_m[2]) - NUM_W'(r_s1_m[6]);
                n_c2.d2 = NUM_W'(r_s1_m[3]) - NUM_W'(r_s1_m[1]);
            end
        endcase
    end

    // ---------------- square root, one result bit per stage
    logic            r_sq_v   [RTW+1];
    logic [VW-1:0]   r_sq_val [RTW+1];
    logic [VW-1:0]   r_sq_res [RTW+1];
    t_sq_carry       r_sq_c   [RTW+1];

    logic [VW-1:0]   n_sq_val [RTW+1];
    logic [VW-1:0]   n_sq_res [RTW+1];

    always_comb begin
        logic [VW-1:0] bitk;
        logic [VW-1:0] trial;
        n_sq_val[0] = VW'(rad_u) << FRAC_BITS;
        n_sq_res[0] = '0;
        for (int k = 0; k < RTW; k++) begin
            bitk  = VW'(1) << (2 * (RTW - 1 - k));
            trial = r_sq_res[k] + bitk;
            if (r_sq_val[k] >= trial) begin
                n_sq_val[k+1] = r_sq_val[k] - trial;
                n_sq_res[k+1] = (r_sq_res[k] >> 1) + bitk;
            end else begin
                n_sq_val[k+1] = r_sq_val[k];
                n_sq_res[k+1] = r_sq_res[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= RTW; k++) r_sq_v[k] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= r_s1_v;
            for (int k = 0; k < RTW; k++) r_sq_v[k+1] <= r_sq_v[k];
        end
        if (en) begin
            r_sq_val[0] <= n_sq_val[0];
            r_sq_res[0] <= n_sq_res[0];
            r_sq_c[0]   <= n_c2;
            for (int k = 0; k < RTW; k++) begin
                r_sq_val[k+1] <= n_sq_val[k+1];
                r_sq_res[k+1] <= n_sq_res[k+1];
                r_sq_c[k+1]   <= r_sq_c[k];
            end
        end
    end

    // ---------------- divider setup: dividend, divisor, overflow
    logic [RTW-1:0]   root;
    logic [RTW:0]     half_w;
    logic [WW-1:0]    den_w;
    logic [NUM_W-1:0] mag [3];
    logic [WW-1:0]    dvd [3];
    logic [2:0]       n_ovf;
    t_dv_carry        n_dc;
    logic signed [NUM_W-1:0] num [3];

    always_comb begin
        root   = r_sq_res[RTW][RTW-1:0];
        half_w = ({1'b0, root} + (RTW+1)'(1)) >> 1;
        den_w  = WW'(root) << 1;
        num[0] = r_sq_c[RTW].d0;
        num[1] = r_sq_c[RTW].d1;
        num[2] = r_sq_c[RTW].d2;
        for (int c = 0; c < 3; c++) begin
            n_dc.neg[c] = num[c][NUM_W-1];
            mag[c]      = num[c][NUM_W-1] ? -num[c] : num[c];
            dvd[c]      = (WW'(mag[c]) << FRAC_BITS) + WW'(root);
            n_ovf[c]    = dvd[c] >= (den_w << QB);
        end
        n_dc.sel   = r_sq_c[RTW].sel;
        n_dc.degen = r_sq_c[RTW].degen;
        n_dc.half  = (HX'(half_w) > HX'(32767)) ? 16'h7fff : ELEM_W'(half_w);
    end

    // ---------------- restoring division, one quotient bit per stage
    logic            r_dv_v   [QB+1];
    logic [RTW:0]    r_dv_den [QB+1];
    logic [WW-1:0]   r_dv_rem [QB+1][3];
    logic [QB-1:0]   r_dv_q   [QB+1][3];
    logic [2:0]      r_dv_ovf [QB+1];
    t_dv_carry       r_dv_c   [QB+1];

    logic [WW-1:0]   n_dv_rem [QB+1][3];
    logic [QB-1:0]   n_dv_q   [QB+1][3];

    always_comb begin
        logic [WW-1:0] dsh;
        for (int c = 0; c < 3; c++) begin
            n_dv_rem[0][c] = dvd[c];
            n_dv_q[0][c]   = '0;
        end
        for (int t = 0; t < QB; t++) begin
            dsh = WW'(r_dv_den[t]) << (QB - 1 - t);
            for (int c = 0; c < 3; c++) begin
                n_dv_rem[t+1][c] = r_dv_rem[t][c];
                n_dv_q[t+1][c]   = r_dv_q[t][c];
                if (r_dv_rem[t][c] >= dsh) begin
                    n_dv_rem[t+1][c]           = r_dv_rem[t][c] - dsh;
                    n_dv_q[t+1][c][QB-1-t]     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t <= QB; t++) r_dv_v[t] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_sq_v[RTW];
            for (int t = 0; t < QB; t++) r_dv_v[t+1] <= r_dv_v[t];
        end
        if (en) begin
            r_dv_den[0] <= den_w[RTW:0];
            r_dv_ovf[0] <= n_ovf;
            r_dv_c[0]   <= n_dc;
            r_dv_rem[0] <= n_dv_rem[0];
            r_dv_q[0]   <= n_dv_q[0];
            for (int t = 0; t < QB; t++) begin
                r_dv_den[t+1] <= r_dv_den[t];
                r_dv_ovf[t+1] <= r_dv_ovf[t];
                r_dv_c[t+1]   <= r_dv_c[t];
                r_dv_rem[t+1] <= n_dv_rem[t+1];
                r_dv_q[t+1]   <= n_dv_q[t+1];
            end
        end
    end

    // ---------------- saturation and component routing
    logic [ELEM_W-1:0] cq [3];
    logic [OUT_W-1:0]  res_data;
    logic              res_degen;
    t_dv_carry         fc;

    always_comb begin
        fc = r_dv_c[QB];
        for (int c = 0; c < 3; c++) begin
            cq[c] = fc.degen ? '0
                  : sat16(fc.neg[c], r_dv_ovf[QB][c], r_dv_q[QB][c]);
        end
        res_degen = fc.degen;
        // packed as {qz, qy, qx, qw}
        unique case (fc.sel)
            SEL_I0:  res_data = {cq[2], cq[1], fc.half, cq[0]};
            SEL_I1:  res_data = {cq[1], fc.half, cq[2], cq[0]};
            SEL_I2:  res_data = {fc.half, cq[2], cq[1], cq[0]};
            default: res_data = {cq[2], cq[1], cq[0], fc.half};
        endcase
    end

    // ---------------- output register and skid register
    logic             r_out_v;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_degen;
    logic [OUT_W-1:0] r_skid_data;
    logic             r_skid_degen;
    logic             out_free;

    assign out_free = ~r_out_v | i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (i_m_axis_tready) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end
            end else if (r_dv_v[QB]) begin
                if (out_free) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
        if (r_skid_v) begin
            if (i_m_axis_tready) begin
                r_out_data  <= r_skid_data;
                r_out_degen <= r_skid_degen;
            end
        end else if (r_dv_v[QB]) begin
            if (out_free) begin
                r_out_data  <= res_data;
                r_out_degen <= res_degen;
            end else begin
                r_skid_data  <= res_data;
                r_skid_degen <= res_degen;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_degen;

    // ---------------- checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_axis_tready))
        else $error("skid filled without an output stall");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("degenerate result with nonzero quaternion");

    a_ready_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_m_axis_tready) |=> r_skid_v)
        else $error("skid content dropped during stall");

endmodule
